### src/rfp_pkg.sv
// shared types and constants for the rtu frame parser with crc-16
package rfp_pkg;

    // crc-16 constants, reflected form
    localparam logic [15:0] CRC_START = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    // status codes carried on the result beat
    localparam logic [1:0] ST_BUSY     = 2'd0;
    localparam logic [1:0] ST_VALID    = 2'd1;
    localparam logic [1:0] ST_CRC_ERR  = 2'd2;
    localparam logic [1:0] ST_FINISHED = 2'd3;

    // widths of the stream payloads
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned IN_USER_W  = 1;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned OUT_USER_W = 3;

    // one result item
    typedef struct packed {
        logic [1:0] status;
        logic       data_valid;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic [7:0] frame_addr_out;
        logic [7:0] frame_func_out;
        logic [7:0] frame_len_out;
    } t_result;

endpackage

### src/rfp_crc_byte.sv
// one-byte update of the reflected crc-16 as an xor network
module rfp_crc_byte (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    // eight shift steps, unrolled into xor terms
    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ rfp_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

### src/rfp_parser.sv
// frame parser state and per-byte result logic
module rfp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_restart,
    output rfp_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        PH_ADDR = 3'd0,
        PH_FUNC = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CHK1 = 3'd4,
        PH_CHK2 = 3'd5,
        PH_HELD = 3'd6
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_addr, n_addr;
    logic [7:0]  r_func, n_func;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_chk_low, n_chk_low;

    t_phase      cur_phase;
    logic [15:0] crc_base;
    logic [15:0] crc_next;
    logic [7:0]  count_inc;

    // restart forces the address phase for this beat
    assign cur_phase = i_restart ? PH_ADDR : r_phase;
    assign crc_base  = (cur_phase == PH_ADDR) ? rfp_pkg::CRC_START : r_crc;
    assign count_inc = r_count + 8'd1;

    rfp_crc_byte u_crc (
        .i_crc  (crc_base),
        .i_byte (i_byte),
        .o_crc  (crc_next)
    );

    // next state and result for the current byte
    always_comb begin
        n_phase   = r_phase;
        n_addr    = r_addr;
        n_func    = r_func;
        n_len     = r_len;
        n_count   = r_count;
        n_crc     = r_crc;
        n_chk_low = r_chk_low;
        o_result  = '0;
        o_result.status = rfp_pkg::ST_BUSY;
        unique case (cur_phase)
            PH_ADDR: begin
                n_addr  = i_byte;
                n_func  = 8'h00;
                n_len   = 8'h00;
                n_count = 8'h00;
                n_crc   = crc_next;
                n_phase = PH_FUNC;
            end
            PH_FUNC: begin
                n_func  = i_byte;
                n_crc   = crc_next;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = i_byte;
                n_crc   = crc_next;
                n_phase = (i_byte != 8'h00) ? PH_DATA : PH_CHK1;
            end
            PH_DATA: begin
                n_crc                = crc_next;
                o_result.data_valid  = 1'b1;
                o_result.data_byte   = i_byte;
                o_result.data_index  = r_count;
                n_count              = count_inc;
                if (count_inc == r_len) begin
                    n_phase = PH_CHK1;
                end
            end
            PH_CHK1: begin
                n_chk_low = i_byte;
                n_phase   = PH_CHK2;
            end
            PH_CHK2: begin
                o_result.status = ({i_byte, r_chk_low} == r_crc) ?
                                  rfp_pkg::ST_VALID : rfp_pkg::ST_CRC_ERR;
                n_phase = PH_HELD;
            end
            default: begin
                o_result.status = rfp_pkg::ST_FINISHED;
            end
        endcase
        o_result.frame_addr_out = n_addr;
        o_result.frame_func_out = n_func;
        o_result.frame_len_out  = n_len;
    end

    // frame state, updated once per processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ADDR;
            r_addr  <= 8'h00;
            r_func  <= 8'h00;
            r_len   <= 8'h00;
            r_count <= 8'h00;
            r_crc   <= rfp_pkg::CRC_START;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_func  <= n_func;
            r_len   <= n_len;
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    // check low byte needs no reset, it is written before it is read
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_chk_low <= n_chk_low;
        end
    end

endmodule

### src/rtu_frame_parser_crc16.sv
// top level: input register, frame parser, result register
//
// channel | dir | tdata (low bit up)                          | tuser (low bit up)
// s_      | in  | in_byte[7:0]                                | restart
// m_      | out | data_byte, data_index, frame_addr_out,      | status[1:0], data_valid
//         |     | frame_func_out, frame_len_out (40 bits)     |
//
// one byte per cycle sustained while m_ takes results; a byte is parsed while it
// sits in the input register and its result is registered into the result register.
// the per-byte crc update is a single xor network between the two registers.
// reset (synchronous, active low) returns the parser to the address phase.
// a stalled m_ side holds the result; s_tready stays high while the input
// register is empty or can move forward into the result register.
module rtu_frame_parser_crc16 (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rfp_pkg::IN_DATA_W-1:0]     s_tdata,   // in_byte
    input  logic [rfp_pkg::IN_USER_W-1:0]     s_tuser,   // restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // data_byte[7:0], data_index[15:8], frame_addr_out[23:16],
    // frame_func_out[31:24], frame_len_out[39:32]
    output logic [rfp_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status[1:0], data_valid[2]
    output logic [rfp_pkg::OUT_USER_W-1:0]    m_tuser
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_restart;
    logic             r_out_valid;
    rfp_pkg::t_result r_out;
    rfp_pkg::t_result step_result;
    logic             step;

    // the held byte moves on when the result register is free or draining
    assign step     = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_byte    <= s_tdata;
            r_in_restart <= s_tuser[0];
        end
    end

    rfp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .i_restart (r_in_restart),
        .o_result  (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_result;
        end
    end

    // output packing
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out.frame_len_out, r_out.frame_func_out, r_out.frame_addr_out,
                       r_out.data_index, r_out.data_byte};
    assign m_tuser  = {r_out.data_valid, r_out.status};

endmodule

### tb/rfp_checker.sv
// scoreboard for the rtu frame parser: byte-level parser model and result compare
package rfp_tb_pkg;

    // one byte of the reflected crc-16, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ rfp_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

module rfp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [rfp_pkg::IN_DATA_W-1:0]     i_s_tdata,   // in_byte
    input  logic [rfp_pkg::IN_USER_W-1:0]     i_s_tuser,   // restart
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // data_byte, data_index, frame_addr_out, frame_func_out, frame_len_out
    input  logic [rfp_pkg::OUT_DATA_W-1:0]    i_m_tdata,
    // status[1:0], data_valid
    input  logic [rfp_pkg::OUT_USER_W-1:0]    i_m_tuser,
    output int                                o_pending,
    output int                                o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PH_ADDR,
        PH_FUNC,
        PH_LEN,
        PH_DATA,
        PH_CHK_LO,
        PH_CHK_HI,
        PH_HELD
    } t_phase;

    // parser state mirrored from the byte stream
    t_phase      phase;
    logic [7:0]  cur_addr;
    logic [7:0]  cur_func;
    logic [7:0]  cur_len;
    logic [7:0]  payload_cnt;
    logic [7:0]  chk_lo;
    logic [15:0] crc_acc;

    rfp_pkg::t_result expected_q[$];
    int               fails = 0;

    function automatic void clear_parser();
        phase       = PH_ADDR;
        cur_addr    = '0;
        cur_func    = '0;
        cur_len     = '0;
        payload_cnt = '0;
        chk_lo      = '0;
        crc_acc     = rfp_pkg::CRC_START;
    endfunction

    // advance the parser by one byte and return the result it should report
    function automatic rfp_pkg::t_result parse_byte(input logic [7:0] b, input logic rs);
        rfp_pkg::t_result r;
        r = '0;
        r.status = rfp_pkg::ST_BUSY;
        if (rs) begin
            phase = PH_ADDR;
        end
        case (phase)
            PH_ADDR: begin
                // new frame: crc restarts, header fields cleared until received
                cur_addr    = b;
                cur_func    = '0;
                cur_len     = '0;
                payload_cnt = '0;
                crc_acc     = rfp_tb_pkg::crc16_byte(rfp_pkg::CRC_START, b);
                phase       = PH_FUNC;
            end
            PH_FUNC: begin
                cur_func = b;
                crc_acc  = rfp_tb_pkg::crc16_byte(crc_acc, b);
                phase    = PH_LEN;
            end
            PH_LEN: begin
                // zero length skips straight to the checksum
                cur_len = b;
                crc_acc = rfp_tb_pkg::crc16_byte(crc_acc, b);
                phase   = (b != 8'h00) ? PH_DATA : PH_CHK_LO;
            end
            PH_DATA: begin
                crc_acc      = rfp_tb_pkg::crc16_byte(crc_acc, b);
                r.data_valid = 1'b1;
                r.data_byte  = b;
                r.data_index = payload_cnt;
                payload_cnt  = payload_cnt + 8'd1;
                if (payload_cnt == cur_len) begin
                    phase = PH_CHK_LO;
                end
            end
            PH_CHK_LO: begin
                chk_lo = b;
                phase  = PH_CHK_HI;
            end
            PH_CHK_HI: begin
                r.status = ({b, chk_lo} == crc_acc) ? rfp_pkg::ST_VALID
                                                    : rfp_pkg::ST_CRC_ERR;
                phase    = PH_HELD;
            end
            default: begin
                r.status = rfp_pkg::ST_FINISHED;
            end
        endcase
        r.frame_addr_out = cur_addr;
        r.frame_func_out = cur_func;
        r.frame_len_out  = cur_len;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fails++;
        end
    endfunction

    // compare result beats first, then record the prediction for an input beat
    always @(posedge i_clk) begin
        rfp_pkg::t_result exp_r;
        if (!i_rst_n) begin
            clear_parser();
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with no prediction pending");
                    fails++;
                end else begin
                    exp_r = expected_q.pop_front();
                    check_field("status", 8'(exp_r.status), 8'(i_m_tuser[1:0]));
                    check_field("data_valid", 8'(exp_r.data_valid), 8'(i_m_tuser[2]));
                    check_field("data_byte", exp_r.data_byte, i_m_tdata[7:0]);
                    check_field("data_index", exp_r.data_index, i_m_tdata[15:8]);
                    check_field("frame_addr_out", exp_r.frame_addr_out, i_m_tdata[23:16]);
                    check_field("frame_func_out", exp_r.frame_func_out, i_m_tdata[31:24]);
                    check_field("frame_len_out", exp_r.frame_len_out, i_m_tdata[39:32]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_q.push_back(parse_byte(i_s_tdata, i_s_tuser[0]));
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fails;
    end

endmodule

### tb/tb_rtu_frame_parser_crc16.sv
// testbench top for the rtu frame parser: clock, reset, frame stimulus and verdict
module tb_rtu_frame_parser_crc16;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS   = 1800;
    localparam int LONG_HOLD = 300;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [rfp_pkg::IN_DATA_W-1:0]  s_tdata;    // in_byte
    logic [rfp_pkg::IN_USER_W-1:0]  s_tuser;    // restart
    logic                           m_tvalid;
    logic                           m_tready;
    logic [rfp_pkg::OUT_DATA_W-1:0] m_tdata;    // data_byte, data_index, addr, func, len
    logic [rfp_pkg::OUT_USER_W-1:0] m_tuser;    // status[1:0], data_valid

    int pending;
    int fail_count;

    // stimulus control shared with the receiver process
    bit tx_steady;
    bit rx_steady;
    bit hold_req;
    int stall_left;

    // beats waiting to go out: {restart, byte}
    logic [8:0] beats_q[$];
    logic [7:0] payload_q[$];

    rtu_frame_parser_crc16 u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rfp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // result side: random back-pressure plus an occasional long hold-off
    initial begin
        int n;
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                n = rx_steady ? 0 : idle_len();
                if (n > 0) begin
                    stall_left = n - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // one input beat; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic rs);
        int n;
        n = tx_steady ? 0 : idle_len();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= rs;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_beats();
        logic [8:0] beat;
        while (beats_q.size() > 0) begin
            beat = beats_q.pop_front();
            send_byte(beat[7:0], beat[8]);
        end
    endtask

    // header, payload from payload_q, crc low then high (crc_flip corrupts it)
    task automatic queue_frame(input logic first_rs, input logic [7:0] addr,
                               input logic [7:0] func, input logic [15:0] crc_flip);
        logic [15:0] crc;
        logic [7:0]  len;
        len = 8'(payload_q.size());
        crc = rfp_tb_pkg::crc16_byte(rfp_pkg::CRC_START, addr);
        crc = rfp_tb_pkg::crc16_byte(crc, func);
        crc = rfp_tb_pkg::crc16_byte(crc, len);
        beats_q.push_back({first_rs, addr});
        beats_q.push_back({1'b0, func});
        beats_q.push_back({1'b0, len});
        foreach (payload_q[i]) begin
            crc = rfp_tb_pkg::crc16_byte(crc, payload_q[i]);
            beats_q.push_back({1'b0, payload_q[i]});
        end
        crc = crc ^ crc_flip;
        beats_q.push_back({1'b0, crc[7:0]});
        beats_q.push_back({1'b0, crc[15:8]});
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)  return 255;
        if (r < 8)  return $urandom_range(9, 254);
        if (r < 20) return 0;
        return $urandom_range(1, 8);
    endfunction

    initial begin
        int items_done;
        int kind;
        int len;
        int cut;
        int held;
        bit second_hold;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        tx_steady  = 1'b0;
        rx_steady  = 1'b0;
        hold_req   = 1'b0;
        items_done = 0;
        second_hold = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-ones address and function with zero length, straight after reset
        payload_q = {};
        queue_frame(1'b0, 8'hFF, 8'hFF, 16'h0000);
        // restart out of the held phase, payload with extreme bytes
        payload_q = {8'h00, 8'hFF};
        queue_frame(1'b1, 8'h01, 8'h03, 16'h0000);
        // checksum error, then a byte while held
        payload_q = {8'hAA};
        queue_frame(1'b1, 8'h80, 8'h7F, 16'h8001);
        beats_q.push_back({1'b0, 8'h55});
        // frame abandoned mid-payload by a restart into an all-zero frame
        beats_q.push_back({1'b1, 8'h12});
        beats_q.push_back({1'b0, 8'h34});
        beats_q.push_back({1'b0, 8'h05});
        beats_q.push_back({1'b0, 8'hC3});
        payload_q = {};
        queue_frame(1'b1, 8'h00, 8'h00, 16'h0000);
        items_done += beats_q.size();
        send_beats();

        // long hold-off on the result side while bytes keep coming
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        for (int i = 0; i < 12; i++) begin
            payload_q.push_back(8'($urandom_range(0, 255)));
        end
        queue_frame(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'h0000);
        payload_q = {};
        items_done += beats_q.size();
        send_beats();

        // random frames, mostly well formed
        while (items_done < N_ITEMS) begin
            tx_steady = ($urandom_range(0, 7) == 0);
            rx_steady = ($urandom_range(0, 7) == 0);
            if (!second_hold && items_done > N_ITEMS / 2) begin
                second_hold = 1'b1;
                tx_steady   = 1'b1;
                hold_req    = 1'b1;
            end
            kind = $urandom_range(0, 99);
            held = 0;
            if (kind < 85) begin
                len = pick_len();
                payload_q = {};
                for (int i = 0; i < len; i++) begin
                    payload_q.push_back(8'($urandom_range(0, 255)));
                end
                queue_frame(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535))
                                                        : 16'h0000);
                if (kind >= 70) begin
                    // broken frame: cut somewhere before its end
                    cut = $urandom_range(1, beats_q.size() - 1);
                    repeat (cut) void'(beats_q.pop_back());
                end else if ($urandom_range(0, 3) == 0) begin
                    held = $urandom_range(1, 2);
                end
            end else begin
                // noise: random bytes with the odd restart among them
                beats_q.push_back({1'b1, 8'($urandom_range(0, 255))});
                repeat ($urandom_range(1, 6)) begin
                    beats_q.push_back({($urandom_range(0, 6) == 0),
                                       8'($urandom_range(0, 255))});
                end
            end
            items_done += beats_q.size();
            // bytes after a finished frame are only answered as finished
            repeat (held) beats_q.push_back({1'b0, 8'($urandom_range(0, 255))});
            send_beats();
        end

        // drain and let any stray beat show up
        s_tvalid <= 1'b0;
        rx_steady = 1'b1;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
src/rfp_pkg.sv
src/rfp_crc_byte.sv
src/rfp_parser.sv
src/rtu_frame_parser_crc16.sv
tb/rfp_checker.sv
tb/tb_rtu_frame_parser_crc16.sv
